@@ rtl/rlfc_pkg.sv @@
// Shared types and constants for the RGB linear fade controller.
package rlfc_pkg;

    localparam int TIME_BITS = 16;
    localparam int CH_W      = 8;
    localparam int PROD_W    = CH_W + TIME_BITS;
    // One spare bit so the rounding-up bias never overflows the dividend
    localparam int DVD_W     = PROD_W + 1;
    localparam int CNT_W     = $clog2(DVD_W);
    localparam int CFG_IDX_W = 4;

    localparam logic [CH_W-1:0]      LEVEL_MAX        = '1;
    localparam logic [TIME_BITS-1:0] INTERVAL_DEFAULT = TIME_BITS'(10);

    localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        CMD_SET,
        CMD_STOP,
        CMD_TICK
    } cmd_t;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DSTART,
        ST_DWAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DVD_W-1:0]     dividend;
        logic [TIME_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/rlfc_div.sv @@
// Restoring divider, one quotient bit per cycle.
module rlfc_div
    import rlfc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [TIME_BITS-1:0] dvs_reg, dvs_next;
    logic [TIME_BITS:0]   rem_shift;
    logic [TIME_BITS:0]   rem_diff;

    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (rem_shift >= {1'b0, dvs_reg}) begin
                rem_next = rem_diff[TIME_BITS-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[TIME_BITS-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ rtl/rgb_linear_fade_controller_top.sv @@
// RGB linear fade controller: command decode, fade sequencer and output register.
//
// Each accepted command returns exactly one beat with the three drive levels and
// the fade flag. Stop, unused commands, immediate sets and ticks that do not
// advance a fade go from the accept straight to the finish state, where the
// result is registered once the output register is free. A set with a fade
// divides fade time by the interval on the shared 25-bit restoring divider. A
// tick that advances a fade runs a multiply and a division for each of the
// three channels on that same divider, in the states MUL, DSTART and DWAIT per
// channel; the divider produces one quotient bit per cycle. The input is not
// ready while a command is in work; a finished result waits in the output
// register while the next command is taken. Configuration writes are taken at
// any time.
module rgb_linear_fade_controller_top
    import rlfc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    input  logic [CH_W-1:0]      s_red_target,
    input  logic [CH_W-1:0]      s_green_target,
    input  logic [CH_W-1:0]      s_blue_target,
    input  logic [TIME_BITS-1:0] s_fade_time_ms,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CH_W-1:0]      m_drive_red,
    output logic [CH_W-1:0]      m_drive_green,
    output logic [CH_W-1:0]      m_drive_blue,
    output logic                 m_fade_active
);

    state_t state_reg, state_next;

    logic                 invert_reg;
    logic [TIME_BITS-1:0] interval_reg;
    logic [CH_W-1:0]      level_r_reg, level_g_reg, level_b_reg;
    logic [3*CH_W-1:0]    start_color_reg, end_color_reg;
    logic [TIME_BITS-1:0] steps_done_reg, steps_total_reg;
    logic                 fading_reg, armed_reg;
    logic [TIME_BITS-1:0] phase_reg;
    chan_t                ch_reg;
    logic                 op_set_reg;
    logic                 down_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [TIME_BITS-1:0] ft_reg;

    logic                 m_valid_reg;
    logic [CH_W-1:0]      drv_r_reg, drv_g_reg, drv_b_reg;
    logic                 m_fade_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                 accept;
    logic                 out_free;
    logic [TIME_BITS-1:0] eff_iv;
    logic [TIME_BITS:0]   phase_inc;
    logic [TIME_BITS-1:0] done_inc;
    logic                 step_now;
    logic [CH_W-1:0]      s_sel, e_sel, diff, new_level;
    logic                 up;
    logic [CH_W-1:0]      q_clamped;

    rlfc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign eff_iv    = (interval_reg == '0) ? TIME_BITS'(1) : interval_reg;
    assign phase_inc = {1'b0, phase_reg} + 1'b1;
    assign done_inc  = steps_done_reg + 1'b1;
    assign step_now  = (phase_reg != '0) && armed_reg && fading_reg;

    // Channel operands for the current fade step
    always_comb begin
        case (ch_reg)
            CH_RED: begin
                s_sel = start_color_reg[3*CH_W-1:2*CH_W];
                e_sel = end_color_reg[3*CH_W-1:2*CH_W];
            end
            CH_GREEN: begin
                s_sel = start_color_reg[2*CH_W-1:CH_W];
                e_sel = end_color_reg[2*CH_W-1:CH_W];
            end
            default: begin
                s_sel = start_color_reg[CH_W-1:0];
                e_sel = end_color_reg[CH_W-1:0];
            end
        endcase
        up   = e_sel >= s_sel;
        diff = up ? (e_sel - s_sel) : (s_sel - e_sel);
        // Falling channel: the quotient is rounded up, clamp at zero
        q_clamped = (div_rsp.quotient > DVD_W'(s_sel)) ? s_sel
                                                       : div_rsp.quotient[CH_W-1:0];
        if (steps_total_reg == '0)
            new_level = e_sel;
        else if (!down_reg)
            new_level = s_sel + div_rsp.quotient[CH_W-1:0];
        else
            new_level = s_sel - q_clamped;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_cmd)
                        CMD_SET:  state_next = (s_fade_time_ms > eff_iv) ? ST_DSTART
                                                                         : ST_FINISH;
                        CMD_TICK: state_next = step_now ? ST_MUL : ST_FINISH;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_MUL:    state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT: begin
                if (div_rsp.done)
                    state_next = (op_set_reg || ch_reg == CH_BLUE) ? ST_FINISH : ST_MUL;
            end
            ST_FINISH: begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DVD_W'(prod_reg);
        div_req.divisor  = steps_total_reg;
        unique case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_DSTART: begin
                div_req.start = 1'b1;
                if (op_set_reg) begin
                    div_req.dividend = DVD_W'(ft_reg);
                    div_req.divisor  = eff_iv;
                end else if (down_reg) begin
                    div_req.dividend = DVD_W'(prod_reg) + DVD_W'(steps_total_reg)
                                     - DVD_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            invert_reg      <= 1'b0;
            interval_reg    <= INTERVAL_DEFAULT;
            level_r_reg     <= '0;
            level_g_reg     <= '0;
            level_b_reg     <= '0;
            start_color_reg <= '0;
            end_color_reg   <= '0;
            steps_done_reg  <= '0;
            steps_total_reg <= '0;
            fading_reg      <= 1'b0;
            armed_reg       <= 1'b0;
            phase_reg       <= '0;
            ch_reg          <= CH_RED;
            op_set_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_INVERT:   invert_reg   <= cfg_data[0];
                    CFG_INTERVAL: interval_reg <= cfg_data[TIME_BITS-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                ch_reg     <= CH_RED;
                op_set_reg <= (s_cmd == CMD_SET);
                case (s_cmd)
                    CMD_SET: begin
                        if (s_fade_time_ms <= eff_iv) begin
                            fading_reg  <= 1'b0;
                            level_r_reg <= s_red_target;
                            level_g_reg <= s_green_target;
                            level_b_reg <= s_blue_target;
                        end else begin
                            fading_reg      <= 1'b1;
                            steps_done_reg  <= '0;
                            start_color_reg <= {level_r_reg, level_g_reg, level_b_reg};
                            end_color_reg   <= {s_red_target, s_green_target,
                                                s_blue_target};
                        end
                    end
                    CMD_STOP: fading_reg <= 1'b0;
                    CMD_TICK: begin
                        if (phase_reg != '0) begin
                            if (armed_reg) begin
                                armed_reg <= 1'b0;
                                if (fading_reg) begin
                                    steps_done_reg <= done_inc;
                                    if (done_inc >= steps_total_reg)
                                        fading_reg <= 1'b0;
                                end
                            end
                        end else begin
                            armed_reg <= 1'b1;
                        end
                        if (phase_inc >= {1'b0, eff_iv})
                            phase_reg <= '0;
                        else
                            phase_reg <= phase_inc[TIME_BITS-1:0];
                    end
                    default: ;
                endcase
            end

            if (state_reg == ST_DWAIT && div_rsp.done) begin
                if (op_set_reg) begin
                    steps_total_reg <= div_rsp.quotient[TIME_BITS-1:0];
                end else begin
                    case (ch_reg)
                        CH_RED:   level_r_reg <= new_level;
                        CH_GREEN: level_g_reg <= new_level;
                        default:  level_b_reg <= new_level;
                    endcase
                    // advance to the next channel
                    case (ch_reg)
                        CH_RED:   ch_reg <= CH_GREEN;
                        default:  ch_reg <= CH_BLUE;
                    endcase
                end
            end

            if (state_reg == ST_FINISH && out_free)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end

        if (accept)
            ft_reg <= s_fade_time_ms;
        if (state_reg == ST_MUL) begin
            prod_reg <= PROD_W'(diff) * PROD_W'(steps_done_reg);
            down_reg <= !up;
        end
        if (state_reg == ST_FINISH && out_free) begin
            drv_r_reg  <= invert_reg ? (LEVEL_MAX - level_r_reg) : level_r_reg;
            drv_g_reg  <= invert_reg ? (LEVEL_MAX - level_g_reg) : level_g_reg;
            drv_b_reg  <= invert_reg ? (LEVEL_MAX - level_b_reg) : level_b_reg;
            m_fade_reg <= fading_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_red   = drv_r_reg;
    assign m_drive_green = drv_g_reg;
    assign m_drive_blue  = drv_b_reg;
    assign m_fade_active = m_fade_reg;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DWAIT)
        else $error("divider finished outside of the wait state");

    a_fade_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (fading_reg && state_reg == ST_IDLE) |-> steps_done_reg < steps_total_reg)
        else $error("fade running past its step total");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> m_valid_reg)
        else $error("finished command produced no result beat");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DWAIT) |-> !s_ready)
        else $error("input ready while a division is in work");
`endif

endmodule

@@ tb/rgb_linear_fade_controller_top_tb.sv @@
// Self-checking testbench for the RGB linear fade controller: directed and random commands.
`timescale 1ns / 1ps

module rgb_linear_fade_controller_top_tb;
    import rlfc_pkg::*;

    localparam int         CLK_HALF    = 4;
    localparam int         STALL_LIMIT = 4000;
    localparam int         REPORT_MAX  = 10;
    localparam int         DRAIN_WAIT  = 100;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [CH_W-1:0]      red;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      blue;
        logic [TIME_BITS-1:0] fade_ms;
    } color_cmd_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            active;
    } drive_t;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [31:0]          cfg_data       = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_cmd          = '0;
    logic [CH_W-1:0]      s_red_target   = '0;
    logic [CH_W-1:0]      s_green_target = '0;
    logic [CH_W-1:0]      s_blue_target  = '0;
    logic [TIME_BITS-1:0] s_fade_time_ms = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [CH_W-1:0]      m_drive_red;
    logic [CH_W-1:0]      m_drive_green;
    logic [CH_W-1:0]      m_drive_blue;
    logic                 m_fade_active;

    rgb_linear_fade_controller_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_red_target   (s_red_target),
        .s_green_target (s_green_target),
        .s_blue_target  (s_blue_target),
        .s_fade_time_ms (s_fade_time_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive_red    (m_drive_red),
        .m_drive_green  (m_drive_green),
        .m_drive_blue   (m_drive_blue),
        .m_fade_active  (m_fade_active)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Fade engine shadow state, index 0 red, 1 green, 2 blue
    logic [CH_W-1:0]      level_now  [3] = '{default: '0};
    logic [CH_W-1:0]      fade_from  [3] = '{default: '0};
    logic [CH_W-1:0]      fade_to    [3] = '{default: '0};
    logic [TIME_BITS-1:0] step_cnt       = '0;
    logic [TIME_BITS-1:0] step_total     = '0;
    logic [TIME_BITS-1:0] phase_ms       = '0;
    logic                 fading         = 1'b0;
    logic                 armed          = 1'b0;
    logic                 invert_cfg     = 1'b0;
    logic [TIME_BITS-1:0] interval_cfg   = INTERVAL_DEFAULT;

    color_cmd_t pending_cmds [$];
    drive_t     expected_drive [$];
    color_cmd_t next_cmd;

    logic in_taken = 1'b0;
    logic calm     = 1'b0;
    int   errors;
    int   stall_cycles;
    int   beats_out;
    int   step_events;
    int   cfg_writes;
    int   cmd_seen [4];

    function automatic int unsigned eff_interval();
        return (interval_cfg == 0) ? 1 : interval_cfg;
    endfunction

    // Linear blend, floored in both directions
    function automatic logic [CH_W-1:0] blend_level(logic [CH_W-1:0] from, logic [CH_W-1:0] to,
                                                    logic [TIME_BITS-1:0] k,
                                                    logic [TIME_BITS-1:0] n);
        longint unsigned span;
        longint unsigned q;
        if (n == 0)
            return to;
        if (to >= from) begin
            span = (64'(to) - 64'(from)) * 64'(k);
            return CH_W'(64'(from) + span / 64'(n));
        end
        span = (64'(from) - 64'(to)) * 64'(k);
        q = (span + 64'(n) - 64'(1)) / 64'(n);
        if (q > 64'(from))
            q = 64'(from);
        return CH_W'(64'(from) - q);
    endfunction

    function automatic drive_t predict_drive(color_cmd_t c);
        drive_t      d;
        int unsigned iv;
        iv = eff_interval();
        case (c.cmd)
            CMD_SET: begin
                if (c.fade_ms <= iv) begin
                    fading = 1'b0;
                    level_now = '{c.red, c.green, c.blue};
                end else begin
                    fading     = 1'b1;
                    step_total = TIME_BITS'(c.fade_ms / iv);
                    step_cnt   = '0;
                    fade_from  = level_now;
                    fade_to    = '{c.red, c.green, c.blue};
                end
            end
            CMD_STOP: fading = 1'b0;
            CMD_TICK: begin
                if (phase_ms != 0) begin
                    // Consume the arm; step only if a fade runs
                    if (armed) begin
                        armed = 1'b0;
                        if (fading) begin
                            step_cnt = step_cnt + 1'b1;
                            for (int ch = 0; ch < 3; ch++)
                                level_now[ch] = blend_level(fade_from[ch], fade_to[ch],
                                                            step_cnt, step_total);
                            if (step_cnt >= step_total)
                                fading = 1'b0;
                            step_events++;
                        end
                    end
                end else begin
                    armed = 1'b1;
                end
                if (32'(phase_ms) + 1 >= iv)
                    phase_ms = '0;
                else
                    phase_ms = phase_ms + 1'b1;
            end
            default: ;
        endcase
        d.red    = invert_cfg ? LEVEL_MAX - level_now[0] : level_now[0];
        d.green  = invert_cfg ? LEVEL_MAX - level_now[1] : level_now[1];
        d.blue   = invert_cfg ? LEVEL_MAX - level_now[2] : level_now[2];
        d.active = fading;
        return d;
    endfunction

    // Source: hold the beat until taken, then load the next one or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
                next_cmd = pending_cmds.pop_front();
                s_valid        <= 1'b1;
                s_cmd          <= next_cmd.cmd;
                s_red_target   <= next_cmd.red;
                s_green_target <= next_cmd.green;
                s_blue_target  <= next_cmd.blue;
                s_fade_time_ms <= next_cmd.fade_ms;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= calm || $urandom_range(0, 99) >= 30;
    end

    always @(posedge aclk) begin
        drive_t     want;
        drive_t     got;
        color_cmd_t acc;
        in_taken = aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_drive_red, m_drive_green, m_drive_blue, m_fade_active};
                if (expected_drive.size() == 0) begin
                    if (errors < REPORT_MAX)
                        $display("ERROR: unexpected result beat %0d: r=%0d g=%0d b=%0d fade=%0d",
                                 beats_out, got.red, got.green, got.blue, got.active);
                    errors++;
                end else begin
                    want = expected_drive.pop_front();
                    if (got != want) begin
                        if (errors < REPORT_MAX)
                            $display({"ERROR: beat %0d expected r=%0d g=%0d b=%0d fade=%0d,",
                                      " got r=%0d g=%0d b=%0d fade=%0d"}, beats_out,
                                     want.red, want.green, want.blue, want.active,
                                     got.red, got.green, got.blue, got.active);
                        errors++;
                    end
                end
                beats_out++;
            end
            if (in_taken) begin
                acc = '{s_cmd, s_red_target, s_green_target, s_blue_target, s_fade_time_ms};
                expected_drive.push_back(predict_drive(acc));
                cmd_seen[s_cmd]++;
            end
            if ((m_valid && m_ready) || in_taken || (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("ERROR: no handshake for %0d cycles, %0d results outstanding",
                             STALL_LIMIT, expected_drive.size());
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    task automatic push_cmd(logic [1:0] op, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                            logic [CH_W-1:0] b, logic [TIME_BITS-1:0] ft);
        pending_cmds.push_back('{op, r, g, b, ft});
    endtask

    task automatic push_ticks(int n);
        repeat (n) push_cmd(CMD_TICK, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                            TIME_BITS'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_BITS-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 32'(val);
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_INVERT)
            invert_cfg = val[0];
        else
            interval_cfg = val;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_drive.size() != 0 || s_valid)
            @(posedge aclk);
    endtask

    task automatic reconfigure(logic inv, logic [TIME_BITS-1:0] iv);
        wait_drained();
        write_reg(CFG_INVERT, TIME_BITS'(inv));
        write_reg(CFG_INTERVAL, iv);
    endtask

    // Mostly ticks; most sets aim at fades of 2 to 12 steps so they run to the end, the rest are immediate or random
    task automatic fill_random(int n);
        color_cmd_t      c;
        int unsigned     iv;
        int unsigned     pick;
        longint unsigned ft;
        iv = eff_interval();
        repeat (n) begin
            c = '{CMD_TICK, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom),
                  TIME_BITS'($urandom)};
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                c.cmd = CMD_SET;
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    ft = 64'(iv) * 64'($urandom_range(2, 12)) + 64'($urandom_range(0, iv - 1));
                    if (ft <= 65535)
                        c.fade_ms = TIME_BITS'(ft);
                end else if (pick < 80) begin
                    c.fade_ms = TIME_BITS'($urandom_range(0, iv));
                end
            end else if (pick < 25) begin
                c.cmd = CMD_STOP;
            end else if (pick < 29) begin
                c.cmd = CMD_UNUSED;
            end
            pending_cmds.push_back(c);
        end
    endtask

    int               phase_inv [9] = '{0, 1, 0, 1, 1, 0, 1, 0, 1};
    int unsigned      phase_iv  [9] = '{2, 3, 1, 5, 0, 12, 65535, 2, 4};
    int               phase_len [9] = '{300, 250, 60, 250, 60, 250, 50, 250, 230};

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: immediate sets at both extremes, unused code, long fade, stop
        push_cmd(CMD_SET, 8'hFF, 8'hFF, 8'hFF, 16'd0);
        push_cmd(CMD_SET, 8'h00, 8'h00, 8'h00, 16'd10);
        push_cmd(CMD_UNUSED, 8'hA5, 8'h5A, 8'hFF, 16'hFFFF);
        push_cmd(CMD_SET, 8'hFF, 8'h00, 8'hAA, 16'hFFFF);
        push_ticks(1);
        push_cmd(CMD_STOP, 8'h00, 8'hFF, 8'h00, 16'h0000);

        // Inverted outputs, short interval: fade up to completion, then a fade with red falling and blue rising
        reconfigure(1'b1, 16'd2);
        push_cmd(CMD_SET, 8'h80, 8'hFF, 8'h00, 16'd9);
        push_ticks(8);
        push_cmd(CMD_SET, 8'h00, 8'hFF, 8'hFF, 16'd5);
        push_ticks(4);

        // Longest interval, then shrink it to zero below the running phase
        reconfigure(1'b0, 16'hFFFF);
        push_cmd(CMD_SET, 8'h01, 8'h02, 8'h03, 16'hFFFF);
        push_ticks(2);
        reconfigure(1'b1, 16'd0);
        push_ticks(1);
        push_cmd(CMD_SET, 8'hFF, 8'hFF, 8'hFF, 16'd1);
        push_cmd(CMD_SET, 8'h00, 8'h00, 8'h00, 16'd2);
        push_ticks(1);
        push_cmd(CMD_STOP, 8'hFF, 8'h00, 8'hFF, 16'hFFFF);

        for (int p = 0; p < 9; p++) begin
            if (p == 5)
                phase_iv[p] = $urandom_range(6, 20);
            reconfigure(phase_inv[p][0], TIME_BITS'(phase_iv[p]));
            calm = (p == 7);
            fill_random(phase_len[p]);
        end

        wait_drained();
        calm = 1'b0;
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Ran %0d commands (set %0d, stop %0d, tick %0d, unused %0d), %0d results checked",
                 cmd_seen[CMD_SET] + cmd_seen[CMD_STOP] + cmd_seen[CMD_TICK]
                 + cmd_seen[CMD_UNUSED], cmd_seen[CMD_SET], cmd_seen[CMD_STOP],
                 cmd_seen[CMD_TICK], cmd_seen[CMD_UNUSED], beats_out);
        $display("%0d fade steps across %0d register writes, %0d mismatches",
                 step_events, cfg_writes, errors);
        if (errors == 0 && expected_drive.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
